[src/json_string_unescape_assert.svh]
// ----------------------------------------------------------------------------
// json_string_unescape_assert
// Assertion macros for the JSON string unescape RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

`ifndef SYNTH

// Implication checked every clock outside reset
`define JSU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be true outside reset
`define JSU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define JSU_ASSERT(lbl, clk, rstn, prop, msg)
`define JSU_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[src/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants for the JSON string unescape block.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    // Most bytes one source byte can turn into
    localparam int unsigned REC_BYTES = 6;
    localparam int unsigned REC_CNT_W = $clog2(REC_BYTES + 1);
    localparam int unsigned REC_IDX_W = $clog2(REC_BYTES);

    // Decoder modes
    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_ESC   = 3'd1;
    localparam logic [2:0] MODE_HEX0  = 3'd2;
    localparam logic [2:0] MODE_HEX1  = 3'd3;
    localparam logic [2:0] MODE_HEX2  = 3'd4;
    localparam logic [2:0] MODE_HEX3  = 3'd5;

    // Characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;

    // UTF-8 lead and continuation marks
    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;

    // One decoded group: up to six bytes for one source byte
    typedef struct packed {
        logic                          last;
        logic [REC_CNT_W-1:0]          cnt;
        logic [REC_BYTES-1:0][7:0]     bytes;
    } t_rec;

    // Hex digit test and value
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Accepts source bytes, tracks the escape state and builds one group of
// decoded bytes for each source byte that yields any.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front import jsu_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_end,
    input  wire logic       i_full,
    output logic            o_push,
    output t_rec            o_rec
);

    logic [2:0]                  r_mode, n_mode;
    logic [15:0]                 r_cp, n_cp;
    logic [2:0][7:0]             r_held;
    logic                        w_accept;
    logic [4:0]                  w_hex;
    logic [1:0]                  w_cnt;
    logic [15:0]                 w_cp_new;
    logic                        w_plain;
    logic [REC_BYTES-1:0][7:0]   w_bytes;
    logic [REC_CNT_W-1:0]        w_n;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign w_hex    = hex_decode(i_byte);
    assign w_cnt    = 2'(r_mode - MODE_HEX0);
    assign w_cp_new = {r_cp[11:0], w_hex[3:0]};

    // Decode one source byte
    always_comb begin
        n_mode  = r_mode;
        n_cp    = r_cp;
        w_bytes = '0;
        w_n     = '0;
        w_plain = 1'b0;
        unique case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_PLAIN;
                unique case (i_byte)
                    CH_QUOTE: begin w_bytes[0] = CH_QUOTE; w_n = 3'd1; end
                    CH_BSL:   begin w_bytes[0] = CH_BSL;   w_n = 3'd1; end
                    CH_SLASH: begin w_bytes[0] = CH_SLASH; w_n = 3'd1; end
                    CH_N:     begin w_bytes[0] = CH_LF;    w_n = 3'd1; end
                    CH_R:     begin w_bytes[0] = CH_CR;    w_n = 3'd1; end
                    CH_T:     begin w_bytes[0] = CH_TAB;   w_n = 3'd1; end
                    CH_B:     begin w_bytes[0] = CH_BS;    w_n = 3'd1; end
                    CH_F:     begin w_bytes[0] = CH_FF;    w_n = 3'd1; end
                    CH_U: begin
                        if (i_end) begin
                            w_bytes[0] = CH_BSL;
                            w_bytes[1] = CH_U;
                            w_n        = 3'd2;
                        end else begin
                            n_mode = MODE_HEX0;
                            n_cp   = '0;
                        end
                    end
                    default: begin
                        w_bytes[0] = CH_BSL;
                        w_bytes[1] = i_byte;
                        w_n        = 3'd2;
                    end
                endcase
            end
            MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                if (!w_hex[4] || (i_end && w_cnt != 2'd3)) begin
                    // flush "\u" and the digits held so far
                    w_bytes[0] = CH_BSL;
                    w_bytes[1] = CH_U;
                    for (int k = 0; k < 3; k++) begin
                        if (k < int'(w_cnt)) begin
                            w_bytes[2 + k] = r_held[k];
                        end
                    end
                    w_n = 3'(w_cnt) + 3'd2;
                    if (w_hex[4]) begin
                        // string ended on a valid digit: emit it raw
                        w_bytes[w_n] = i_byte;
                        w_n          = w_n + 3'd1;
                        n_mode       = MODE_PLAIN;
                    end else begin
                        w_plain = 1'b1;
                    end
                end else if (w_cnt != 2'd3) begin
                    n_cp   = w_cp_new;
                    n_mode = r_mode + 3'd1;
                end else begin
                    // four digits: UTF-8 encode
                    n_cp   = w_cp_new;
                    n_mode = MODE_PLAIN;
                    if (w_cp_new < 16'h0080) begin
                        w_bytes[0] = w_cp_new[7:0];
                        w_n        = 3'd1;
                    end else if (w_cp_new < 16'h0800) begin
                        w_bytes[0] = UTF_LEAD2 | {3'b000, w_cp_new[10:6]};
                        w_bytes[1] = UTF_CONT | {2'b00, w_cp_new[5:0]};
                        w_n        = 3'd2;
                    end else begin
                        w_bytes[0] = UTF_LEAD3 | {4'b0000, w_cp_new[15:12]};
                        w_bytes[1] = UTF_CONT | {2'b00, w_cp_new[11:6]};
                        w_bytes[2] = UTF_CONT | {2'b00, w_cp_new[5:0]};
                        w_n        = 3'd3;
                    end
                end
            end
            default: begin
                w_plain = 1'b1;
            end
        endcase

        // ordinary text byte, also after a bad hex digit
        if (w_plain) begin
            if (i_byte == CH_BSL && !i_end) begin
                n_mode = MODE_ESC;
            end else begin
                n_mode       = MODE_PLAIN;
                w_bytes[w_n] = i_byte;
                w_n          = w_n + 3'd1;
            end
        end

        if (i_end) begin
            n_mode = MODE_PLAIN;
            n_cp   = '0;
        end
    end

    assign o_push      = w_accept && (w_n != '0);
    assign o_rec.last  = i_end;
    assign o_rec.cnt   = w_n;
    assign o_rec.bytes = w_bytes;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
            r_cp   <= '0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_cp   <= n_cp;
        end
    end

    // Raw digits kept for a possible flush
    always_ff @(posedge i_clk) begin
        if (w_accept && w_hex[4] && r_mode >= MODE_HEX0 && r_mode <= MODE_HEX2) begin
            r_held[w_cnt] <= i_byte;
        end
    end

endmodule

`default_nettype wire

[src/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue
// Small register queue of decoded groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue import jsu_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_rec      i_rec,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_rec      o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_rec               r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rd];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

[src/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Sends the bytes of the group at the queue head, one word per cycle while i_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back import jsu_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_rec      i_rec,
    output logic      o_pop,
    output logic      o_tvalid,
    input  wire logic i_tready,
    output logic [7:0] o_tdata,
    output logic      o_tlast
);

    logic [REC_IDX_W-1:0] r_idx;
    logic                 w_final;

    assign w_final  = (REC_CNT_W'(r_idx) == i_rec.cnt - 1'b1);
    assign o_tvalid = i_valid;
    assign o_tdata  = i_rec.bytes[r_idx];
    assign o_tlast  = i_rec.last && w_final;
    assign o_pop    = i_valid && i_tready && w_final;

    // Byte index within the current group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_valid && i_tready) begin
            r_idx <= w_final ? '0 : r_idx + 1'b1;
        end
    end

endmodule

`default_nettype wire

[src/json_string_unescape.sv]
// ----------------------------------------------------------------------------
// json_string_unescape
// Decodes the bytes between the quotes of a JSON string: simple escapes,
// unknown escapes passed raw, and \uXXXX turned into UTF-8.
// ----------------------------------------------------------------------------
//  channel   dir  tdata            tlast
//  s_axis    in   in_byte [7:0]    end_of_string
//  m_axis    out  out_byte [7:0]   last_of_string
//
//  A source byte is taken every cycle while the group queue has room.
//  Each source byte yields 0..6 output words; the back end sends one word
//  per cycle while m_axis is ready.
//  The QUEUE_DEPTH-entry group queue sets how long a burst the input rides out.
//  Reset clears the decoder mode, code point, queue and byte index; no
//  clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_string_unescape_assert.svh"

module json_string_unescape import jsu_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tlast,
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic            o_m_axis_tlast
);

    logic w_push, w_pop, w_full, w_qvalid;
    t_rec w_rec_in, w_head;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_end   (i_s_axis_tlast),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_rec   (w_rec_in)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_head  (w_head)
    );

    jsu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .i_rec    (w_head),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

    // Checks
    `JSU_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, w_push && w_full, "group queue overflow")
    `JSU_ASSERT(a_head_count, i_clk, i_rst_n,
        w_qvalid |-> (w_head.cnt != '0 && w_head.cnt <= REC_CNT_W'(REC_BYTES)),
        "bad group size at queue head")
    `JSU_ASSERT(a_last_pops, i_clk, i_rst_n,
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |-> w_pop,
        "last word sent without releasing its group")

endmodule

`default_nettype wire
